// File: rtl/sgs_pkg.sv
package sgs_pkg;

    localparam int NUM_SYMBOLS = 60;
    localparam int MAX_ITEMS   = 4096;
    localparam int SYM_W       = 6;
    localparam int IDX_W       = 6;
    localparam int POS_W       = 13;
    localparam int CNT_W       = 13;
    localparam int GAP_W       = 12;
    localparam int WS_W        = 12;

    localparam logic [WS_W-1:0]  WS_RESET = 12'd1139;
    localparam logic [CNT_W-1:0] CNT_MAX  = 13'd8191;
    localparam logic [GAP_W-1:0] GAP_MAX  = 12'd4095;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SYMBOLS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_RD,
        ST_DIV,
        ST_OUT,
        ST_SHORT,
        ST_CLEAR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic read_sym;     // read table entry of the accepted symbol
        logic write_sym;    // write back the updated entry
        logic skip_pos;     // position advance only
        logic scan_first;   // reset most/least trackers
        logic scan_rd;      // read entry at index for scan
        logic scan_acc;     // fold read count into trackers
        logic idx_clr;
        logic idx_inc;
        logic rep_rd;       // read entry at index for reporting
        logic div_start;
        logic out_load;     // capture the result into the output register
        logic short_load;
        logic clr_wr;       // clear entry at index
        logic pos_clr;
    } sgs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic win_empty;
        logic idx_last;
        logic div_done;
        logic sym_valid;   // symbol counted
        logic pos_full;
    } sgs_sts_t;

endpackage

// File: rtl/sgs_divider.sv
module sgs_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sgs_pkg::GAP_W-1:0]    dividend,
    input  logic [sgs_pkg::CNT_W-1:0]    divisor,
    output logic                         done,
    output logic [sgs_pkg::GAP_W-1:0]    quotient
);

    // restoring division, one quotient bit per cycle
    logic [sgs_pkg::GAP_W-1:0] quo_reg, quo_next;
    logic [sgs_pkg::CNT_W:0]   rem_reg, rem_next;
    logic [sgs_pkg::CNT_W-1:0] den_reg, den_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic [sgs_pkg::CNT_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[sgs_pkg::CNT_W-1:0], quo_reg[sgs_pkg::GAP_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 4'(sgs_pkg::GAP_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[sgs_pkg::GAP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[sgs_pkg::GAP_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = busy_reg && (cnt_reg == 4'd1) && !start;
    assign quotient = quo_next;

endmodule

// File: rtl/sgs_datapath.sv
module sgs_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sgs_pkg::sgs_cmd_t             cmd,
    output sgs_pkg::sgs_sts_t             sts,
    input  logic [sgs_pkg::WS_W-1:0]      window_start,
    input  logic [sgs_pkg::SYM_W-1:0]     in_symbol,
    output logic [sgs_pkg::SYM_W-1:0]     symbol_id,
    output logic [sgs_pkg::CNT_W-1:0]     occurrences,
    output logic [sgs_pkg::GAP_W-1:0]     mean_gap,
    output logic [12:0]                   current_gap,
    output logic [sgs_pkg::GAP_W-1:0]     max_gap,
    output logic [12:0]                   min_gap,
    output logic [sgs_pkg::SYM_W-1:0]     most_symbol,
    output logic [sgs_pkg::CNT_W-1:0]     most_count,
    output logic [sgs_pkg::SYM_W-1:0]     least_symbol,
    output logic [sgs_pkg::CNT_W-1:0]     least_count,
    output logic                          window_short,
    output logic                          last
);

    localparam int EW = sgs_pkg::CNT_W + 4 * sgs_pkg::GAP_W;

    // entry: count, last_seen, gap_sum, smallest, largest
    logic [EW-1:0] mem [sgs_pkg::NUM_SYMBOLS];
    logic [EW-1:0] rd_reg;

    logic [sgs_pkg::POS_W-1:0] pos_reg;
    logic [sgs_pkg::IDX_W-1:0] idx_reg, sym_idx_reg;
    logic [sgs_pkg::POS_W-1:0] p_reg;
    logic [sgs_pkg::SYM_W-1:0] most_s_reg, least_s_reg;
    logic [sgs_pkg::CNT_W-1:0] most_c_reg, least_c_reg;

    logic [sgs_pkg::CNT_W-1:0] e_cnt;
    logic [sgs_pkg::GAP_W-1:0] e_last, e_sum, e_small, e_large;
    logic [sgs_pkg::GAP_W-1:0] ref_v, gap, new_small, new_large, new_sum;
    logic [sgs_pkg::GAP_W:0]   sum_w;
    logic [sgs_pkg::POS_W-1:0] gap_w, cur_w;
    logic [sgs_pkg::CNT_W-1:0] new_cnt;
    logic [sgs_pkg::IDX_W-1:0] rd_addr;
    logic [sgs_pkg::GAP_W-1:0] quo;
    logic                      div_done;
    logic                      sym_ok;

    assign {e_cnt, e_last, e_sum, e_small, e_large} = rd_reg;
    assign ref_v = (e_cnt != '0) ? e_last : window_start;

    assign gap_w = (p_reg >= {1'b0, ref_v}) ? p_reg - {1'b0, ref_v} : '0;
    assign gap   = (gap_w > {1'b0, sgs_pkg::GAP_MAX}) ? sgs_pkg::GAP_MAX
                                                     : gap_w[sgs_pkg::GAP_W-1:0];
    assign sum_w   = {1'b0, e_sum} + {1'b0, gap};
    assign new_sum = sum_w[sgs_pkg::GAP_W] ? sgs_pkg::GAP_MAX : sum_w[sgs_pkg::GAP_W-1:0];
    assign new_small = ((e_cnt == '0) || (gap < e_small)) ? gap : e_small;
    assign new_large = (gap > e_large) ? gap : e_large;
    assign new_cnt   = (e_cnt < sgs_pkg::CNT_MAX) ? e_cnt + 1'b1 : e_cnt;

    assign cur_w = (pos_reg >= {1'b0, ref_v}) ? pos_reg - {1'b0, ref_v} : '0;

    assign sym_ok = (in_symbol >= 6'd1) && (in_symbol <= 6'(sgs_pkg::NUM_SYMBOLS))
                    && (pos_reg >= {1'b0, window_start});
    assign rd_addr = cmd.read_sym ? in_symbol - 6'd1 : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.read_sym || cmd.scan_rd || cmd.rep_rd)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (cmd.write_sym)
        begin
            mem[sym_idx_reg] <= {new_cnt, p_reg[sgs_pkg::GAP_W-1:0], new_sum,
                                 new_small, new_large};
        end
        else if (cmd.clr_wr)
        begin
            mem[idx_reg] <= {{sgs_pkg::CNT_W{1'b0}}, window_start,
                             {sgs_pkg::GAP_W{1'b0}}, sgs_pkg::GAP_MAX,
                             {sgs_pkg::GAP_W{1'b0}}};
        end
        if (cmd.read_sym)
        begin
            sym_idx_reg <= in_symbol - 6'd1;
            p_reg       <= pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.pos_clr)
            begin
                pos_reg <= '0;
            end
            else if ((cmd.read_sym || cmd.skip_pos)
                     && pos_reg < sgs_pkg::POS_W'(sgs_pkg::MAX_ITEMS))
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // most / least trackers; scan_acc folds entry idx_reg-1
    always_ff @(posedge clk)
    begin
        if (cmd.scan_first)
        begin
            most_s_reg  <= '0;
            most_c_reg  <= '0;
            least_s_reg <= 6'd1;
            least_c_reg <= '1;
        end
        else if (cmd.scan_acc)
        begin
            if (e_cnt > most_c_reg)
            begin
                most_c_reg <= e_cnt;
                most_s_reg <= idx_reg;
            end
            if (e_cnt < least_c_reg)
            begin
                least_c_reg <= e_cnt;
                least_s_reg <= idx_reg;
            end
        end
    end

    sgs_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (e_sum),
        .divisor  (e_cnt),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            symbol_id    <= idx_reg + 6'd1;
            occurrences  <= e_cnt;
            mean_gap     <= (e_cnt != '0) ? quo : '0;
            current_gap  <= cur_w;
            max_gap      <= (e_cnt != '0) ? e_large : '0;
            min_gap      <= (e_cnt != '0) ? {1'b0, e_small}
                                          : pos_reg - {1'b0, window_start};
            most_symbol  <= most_s_reg;
            most_count   <= most_c_reg;
            least_symbol <= least_s_reg;
            least_count  <= least_c_reg;
            window_short <= 1'b0;
            last         <= (idx_reg == sgs_pkg::LAST_IDX);
        end
        else if (cmd.short_load)
        begin
            symbol_id    <= '0;
            occurrences  <= '0;
            mean_gap     <= '0;
            current_gap  <= '0;
            max_gap      <= '0;
            min_gap      <= '0;
            most_symbol  <= '0;
            most_count   <= '0;
            least_symbol <= '0;
            least_count  <= '0;
            window_short <= 1'b1;
            last         <= 1'b1;
        end
    end

    assign sts.win_empty = (pos_reg <= {1'b0, window_start});
    assign sts.idx_last  = (idx_reg == sgs_pkg::LAST_IDX);
    assign sts.div_done  = div_done;
    assign sts.sym_valid = sym_ok;
    assign sts.pos_full  = (pos_reg >= sgs_pkg::POS_W'(sgs_pkg::MAX_ITEMS));

endmodule

// File: rtl/sgs_ctrl.sv
module sgs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              in_req_type,
    output logic              out_valid,
    input  logic              out_stall,
    output sgs_pkg::sgs_cmd_t cmd,
    input  sgs_pkg::sgs_sts_t sts
);

    sgs_pkg::state_t state_reg, state_next;
    logic            ov_reg, ov_next;
    logic            acc;

    // scan bookkeeping: last_scan marks the read of the final entry
    logic last_scan_reg, last_scan_next;
    logic div_go, div_go_reg;

    assign in_stall  = (state_reg != sgs_pkg::ST_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign acc       = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        div_go     = 1'b0;
        case (state_reg)
            sgs_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    if (in_req_type)
                    begin
                        if (sts.win_empty)
                        begin
                            state_next = sgs_pkg::ST_SHORT;
                        end
                        else
                        begin
                            cmd.idx_clr    = 1'b1;
                            cmd.scan_first = 1'b1;
                            state_next     = sgs_pkg::ST_SCAN;
                        end
                    end
                    else if (sts.sym_valid && !sts.pos_full)
                    begin
                        cmd.read_sym = 1'b1;
                        state_next   = sgs_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        cmd.skip_pos = 1'b1;
                    end
                end
            end
            sgs_pkg::ST_UPDATE:
            begin
                cmd.write_sym = 1'b1;
                state_next    = sgs_pkg::ST_IDLE;
            end
            sgs_pkg::ST_SCAN:
            begin
                cmd.scan_rd  = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = sgs_pkg::ST_SCAN_LAST;
            end
            sgs_pkg::ST_SCAN_LAST:
            begin
                // entry idx-1 in read register, idx_reg now equals its symbol
                cmd.scan_acc = 1'b1;
                if (last_scan_reg)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = sgs_pkg::ST_RD;
                end
                else
                begin
                    state_next = sgs_pkg::ST_SCAN;
                end
            end
            sgs_pkg::ST_RD:
            begin
                cmd.rep_rd = 1'b1;
                state_next = sgs_pkg::ST_DIV;
                div_go     = 1'b1;
            end
            sgs_pkg::ST_DIV:
            begin
                if (div_go_reg)
                begin
                    cmd.div_start = 1'b1;
                end
                else if (sts.div_done && !ov_reg)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = sgs_pkg::ST_OUT;
                end
            end
            sgs_pkg::ST_OUT:
            begin
                if (!ov_reg)
                begin
                    // result delivered: clear this entry, move on
                    cmd.clr_wr  = 1'b1;
                    cmd.idx_inc = 1'b1;
                    if (sts.idx_last)
                    begin
                        cmd.pos_clr = 1'b1;
                        state_next  = sgs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = sgs_pkg::ST_RD;
                    end
                end
            end
            sgs_pkg::ST_SHORT:
            begin
                if (!ov_reg)
                begin
                    cmd.short_load = 1'b1;
                    ov_next        = 1'b1;
                    cmd.idx_clr    = 1'b1;
                    state_next     = sgs_pkg::ST_CLEAR;
                end
            end
            sgs_pkg::ST_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.idx_inc = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.pos_clr = 1'b1;
                    state_next  = sgs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        last_scan_next = last_scan_reg;
        if (state_reg == sgs_pkg::ST_SCAN)
        begin
            last_scan_next = sts.idx_last;
        end
        else if (state_reg != sgs_pkg::ST_SCAN_LAST)
        begin
            last_scan_next = 1'b0;
        end
    end

    // reset enters the clearing pass so the tables start empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgs_pkg::ST_CLEAR;
            ov_reg        <= 1'b0;
            last_scan_reg <= 1'b0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ov_reg        <= ov_next;
            last_scan_reg <= last_scan_next;
            div_go_reg    <= div_go;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_sym |-> $past(cmd.read_sym))
        else $error("table write without preceding read");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load || cmd.short_load) |-> !ov_reg)
        else $error("output register overwritten");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_sym && cmd.clr_wr))
        else $error("two table writes in one cycle");

endmodule

// File: rtl/symbol_gap_statistics_unit.sv
// channel  | valid      | stall      | payload
// ---------+------------+------------+--------------------------------------------
// input    | in_valid   | in_stall   | req_type, symbol
// output   | out_valid  | out_stall  | symbol_id .. last (one port per field)
// config   | cfg_we     | -          | cfg_data -> window_start
//
// a counted symbol takes a table read, then a write back; other symbol
// transactions make no table access. a report scans the counts of all 60
// entries, then per symbol does a table read, a divider start and 12 serial
// steps, the result handshake and the entry clear.
// an empty-window report emits one result and then clears 60 entries, one a
// cycle. reset starts the same clearing pass; input stalls until done.
// output stalls hold the result register and the report sequencer.
module symbol_gap_statistics_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [5:0]  symbol,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  symbol_id,
    output logic [12:0] occurrences,
    output logic [11:0] mean_gap,
    output logic [12:0] current_gap,
    output logic [11:0] max_gap,
    output logic [12:0] min_gap,
    output logic [5:0]  most_symbol,
    output logic [12:0] most_count,
    output logic [5:0]  least_symbol,
    output logic [12:0] least_count,
    output logic        window_short,
    output logic        last,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data
);

    logic [sgs_pkg::WS_W-1:0] ws_reg;
    sgs_pkg::sgs_cmd_t        cmd;
    sgs_pkg::sgs_sts_t        sts;

    // window start register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= sgs_pkg::WS_RESET;
        end
        else if (cfg_we)
        begin
            ws_reg <= cfg_data;
        end
    end

    sgs_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_req_type (req_type),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

    sgs_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .window_start (ws_reg),
        .in_symbol    (symbol),
        .symbol_id    (symbol_id),
        .occurrences  (occurrences),
        .mean_gap     (mean_gap),
        .current_gap  (current_gap),
        .max_gap      (max_gap),
        .min_gap      (min_gap),
        .most_symbol  (most_symbol),
        .most_count   (most_count),
        .least_symbol (least_symbol),
        .least_count  (least_count),
        .window_short (window_short),
        .last         (last)
    );

endmodule
